// ----- src/bucket_slot_assigner_top_defines.svh -----
// Assertion macros for the bucket slot assigner.
// Depends on clk and rst_n being in scope where the macros are used.
`ifndef BUCKET_SLOT_ASSIGNER_TOP_DEFINES_SVH
`define BUCKET_SLOT_ASSIGNER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bsa_pkg.sv -----
// Shared types and constants of the bucket slot assigner.
// No dependencies; used by every module of the block.
package bsa_pkg;

  localparam int MAX_DEST  = 64;
  localparam int MAX_ITEMS = 65536;
  localparam int DEST_AW   = $clog2(MAX_DEST);
  localparam int ND_W      = 7;
  localparam int CNT_W     = 17;
  localparam int SUM_W     = CNT_W + 1;

  // Queue between front and back; depth must be a power of two.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [ND_W-1:0]  ND_MAX     = ND_W'(MAX_DEST);
  localparam logic [CNT_W-1:0] ITEM_LIM   = CNT_W'(MAX_ITEMS);
  localparam logic [SUM_W-1:0] ITEM_LIM_S = SUM_W'(MAX_ITEMS);
  localparam logic [SUM_W-1:0] SLOT_MAX_S = SUM_W'(MAX_ITEMS - 1);
  localparam logic [CNT_W-1:0] SLOT_MAX   = CNT_W'(MAX_ITEMS - 1);

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_COUNT  = 3'd1;
  localparam logic [2:0] OP_FINAL  = 3'd2;
  localparam logic [2:0] OP_ASSIGN = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  typedef enum logic [2:0] {
    K_CLEAR, K_COUNT, K_FINAL, K_ASSIGN, K_QUERY, K_NOP
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE, B_EXEC, B_FIN
  } back_state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] dest;
    logic [5:0]         query_index;
  } in_item_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] slot;
    logic                    dest_valid;
    logic [CNT_W-1:0]        bucket_count;
    logic [CNT_W-1:0]        bucket_offset;
    logic [CNT_W-1:0]        total_count;
    logic                    overflow;
  } out_item_t;

  // Classified work item handed from front to back.
  typedef struct packed {
    kind_t              kind;
    logic               dv;
    logic [DEST_AW-1:0] idx;
    logic               idx_ok;
    logic [ND_W-1:0]    nd;
  } work_t;

  typedef struct packed {
    logic busy;
    logic walking;
  } back_stat_t;

endpackage

// ----- src/bucket_slot_assigner_top.sv -----
// Top level of the bucket slot assigner: front end, work queue and back end.
// Depends on bsa_pkg, bsa_front, bsa_fifo, bsa_back and the defines header.
//
//   beat      ports                              payload
//   input     in_valid / in_ready                in_data   (bsa_pkg::in_item_t)
//   result    out_valid / out_ready              out_data  (bsa_pkg::out_item_t)
//   config    cfg_wr_en                          cfg_wr_data (num_dest, 7 bits)
//
// In the back end, clear, count, assign, query and unknown ops first read the
// tables (IDLE), then update them and load the result register (EXEC).
// Finalize walks all MAX_DEST entries; the walk reads one count per cycle.
// Reset (rst_n low at a clock edge) empties the queue and marks every table
// entry unwritten, so the tables read as zero; no clearing pass is needed.
// The queue keeps taking input beats while a result waits on out_ready, until it is full.
`include "bucket_slot_assigner_top_defines.svh"

module bucket_slot_assigner_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bsa_pkg::out_item_t out_data
);

  // Queue traffic between the two halves.
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  bsa_pkg::work_t      q_in;
  bsa_pkg::work_t      q_head;
  bsa_pkg::back_stat_t back_stat;

  // Decode op, range-check dest and query_index against the clamped num_dest.
  bsa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  // Hold classified beats so the front keeps accepting while the back is busy.
  bsa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Execute against the tables; advance only when the result register frees up.
  bsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (back_stat)
  );

  // A new result comes only out of a back end that was working on a beat.
  `BSA_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(back_stat.busy), "result without work")
  // During the finalize walk the result register stays empty.
  `BSA_ASSERT_NOW(a_walk_no_result, back_stat.walking, !out_valid, "result during walk")
  // The total never passes the item limit.
  `BSA_ASSERT_NOW(a_total_limit, out_valid, out_data.total_count <= bsa_pkg::ITEM_LIM, "total too big")
  // A walk always ends, and the back end stays busy until it does.
  `BSA_ASSERT_NEXT(a_walk_busy, back_stat.walking, back_stat.busy || out_valid, "walk dropped")

endmodule

// ----- src/bsa_front.sv -----
// Front end: holds num_dest, accepts input beats and classifies them.
// Depends on bsa_pkg.
module bsa_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [6:0]            cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bsa_pkg::in_item_t     in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output bsa_pkg::work_t        q_data
);

  logic [bsa_pkg::ND_W-1:0] num_dest_r;
  logic [bsa_pkg::ND_W-1:0] num_dest_nxt;
  logic [bsa_pkg::ND_W-1:0] nd;
  logic                     dest_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dest_r <= bsa_pkg::ND_W'(1);
    end else begin
      num_dest_r <= num_dest_nxt;
    end
  end

  always_comb begin
    num_dest_nxt = cfg_wr_en ? cfg_wr_data : num_dest_r;
    nd = (num_dest_r > bsa_pkg::ND_MAX) ? bsa_pkg::ND_MAX : num_dest_r;
    dest_ok = !in_data.dest[31]
              && (in_data.dest[30:bsa_pkg::ND_W] == '0)
              && (in_data.dest[bsa_pkg::ND_W-1:0] < nd);

    q_data.dv     = dest_ok;
    q_data.nd     = nd;
    q_data.idx_ok = ({1'b0, in_data.query_index} < nd);
    q_data.idx    = '0;
    case (in_data.op)
      bsa_pkg::OP_CLEAR: begin
        q_data.kind = bsa_pkg::K_CLEAR;
      end
      bsa_pkg::OP_COUNT: begin
        q_data.kind = bsa_pkg::K_COUNT;
        q_data.idx  = in_data.dest[bsa_pkg::DEST_AW-1:0];
      end
      bsa_pkg::OP_FINAL: begin
        q_data.kind = bsa_pkg::K_FINAL;
      end
      bsa_pkg::OP_ASSIGN: begin
        q_data.kind = bsa_pkg::K_ASSIGN;
        q_data.idx  = in_data.dest[bsa_pkg::DEST_AW-1:0];
      end
      bsa_pkg::OP_QUERY: begin
        q_data.kind = bsa_pkg::K_QUERY;
        q_data.idx  = in_data.query_index;
      end
      default: begin
        q_data.kind = bsa_pkg::K_NOP;
      end
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ----- src/bsa_fifo.sv -----
// Short work queue between the front and back ends.
// Depends on bsa_pkg.
module bsa_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bsa_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output bsa_pkg::work_t head,
  output logic           empty
);

  bsa_pkg::work_t            mem_r [bsa_pkg::Q_DEPTH];
  logic [bsa_pkg::Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [bsa_pkg::Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [bsa_pkg::Q_AW:0]    cnt_r, cnt_nxt;

  always_comb begin
    full       = (cnt_r == (bsa_pkg::Q_AW+1)'(bsa_pkg::Q_DEPTH));
    empty      = (cnt_r == '0);
    wr_ptr_nxt = push ? wr_ptr_r + bsa_pkg::Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + bsa_pkg::Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (bsa_pkg::Q_AW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (bsa_pkg::Q_AW+1)'(1);
    end
    head = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/bsa_back.sv -----
// Back end: count, offset and cursor tables, the finalize walk and the result register.
// Depends on bsa_pkg.
module bsa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  bsa_pkg::work_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output bsa_pkg::out_item_t  out_data,
  output bsa_pkg::back_stat_t stat
);

  localparam int AW = bsa_pkg::DEST_AW;
  localparam int CW = bsa_pkg::CNT_W;
  localparam int SW = bsa_pkg::SUM_W;
  localparam int ND = bsa_pkg::MAX_DEST;

  bsa_pkg::back_state_t state_r, state_nxt;
  bsa_pkg::work_t       cur_r, cur_nxt;
  bsa_pkg::out_item_t   out_r, out_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [AW-1:0]        wi_r, wi_nxt;
  logic [CW-1:0]        run_r, run_nxt;
  logic [CW-1:0]        total_r, total_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [ND-1:0]        cnt_vld_r, cnt_vld_nxt;
  logic [ND-1:0]        cur_vld_r, cur_vld_nxt;
  logic [ND-1:0]        off_vld_r, off_vld_nxt;

  logic [CW-1:0] cnt_mem [ND];
  logic [CW-1:0] off_mem [ND];
  logic [CW-1:0] cur_mem [ND];
  logic [CW-1:0] cnt_rd_r, off_rd_r, cur_rd_r;
  logic [AW-1:0] rd_addr;

  logic          cnt_we, off_we, cur_we;
  logic [AW-1:0] off_wa;
  logic [CW-1:0] cnt_wd, off_wd, cur_wd;

  always_comb begin
    logic [CW-1:0]      cnt_v;
    logic [CW-1:0]      off_v;
    logic [CW-1:0]      cup_v;
    logic [CW-1:0]      fin_cnt;
    logic [SW-1:0]      sum;
    logic [SW-1:0]      run_sum;
    bsa_pkg::out_item_t res;

    state_nxt   = state_r;
    cur_nxt     = cur_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    wi_nxt      = wi_r;
    run_nxt     = run_r;
    total_nxt   = total_r;
    ovf_nxt     = ovf_r;
    cnt_vld_nxt = cnt_vld_r;
    cur_vld_nxt = cur_vld_r;
    off_vld_nxt = off_vld_r;
    q_pop       = 1'b0;
    rd_addr     = q_head.idx;
    cnt_we      = 1'b0;
    off_we      = 1'b0;
    cur_we      = 1'b0;
    off_wa      = wi_r;
    cnt_wd      = '0;
    off_wd      = '0;
    cur_wd      = '0;
    res         = '0;
    sum         = '0;
    run_sum     = '0;

    // Unwritten table entries read as zero.
    cnt_v   = cnt_vld_r[cur_r.idx] ? cnt_rd_r : '0;
    off_v   = off_vld_r[cur_r.idx] ? off_rd_r : '0;
    cup_v   = cur_vld_r[cur_r.idx] ? cur_rd_r : '0;
    fin_cnt = cnt_vld_r[wi_r] ? cnt_rd_r : '0;

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      bsa_pkg::B_IDLE: begin
        if (!q_empty && (!out_vld_r || out_ready)) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          if (q_head.kind == bsa_pkg::K_FINAL) begin
            wi_nxt      = '0;
            run_nxt     = '0;
            cur_vld_nxt = '0;
            state_nxt   = bsa_pkg::B_FIN;
          end else begin
            state_nxt = bsa_pkg::B_EXEC;
          end
        end
      end
      bsa_pkg::B_EXEC: begin
        case (cur_r.kind)
          bsa_pkg::K_CLEAR: begin
            cnt_vld_nxt = '0;
            cur_vld_nxt = '0;
          end
          bsa_pkg::K_COUNT: begin
            res.dest_valid = cur_r.dv;
            if (cur_r.dv) begin
              if (cnt_v >= bsa_pkg::ITEM_LIM) begin
                ovf_nxt = 1'b1;
              end else begin
                cnt_we                 = 1'b1;
                cnt_wd                 = cnt_v + CW'(1);
                cnt_vld_nxt[cur_r.idx] = 1'b1;
              end
            end
          end
          bsa_pkg::K_ASSIGN: begin
            res.dest_valid = cur_r.dv;
            if (cur_r.dv) begin
              sum = {1'b0, off_v} + {1'b0, cup_v};
              if (sum > bsa_pkg::SLOT_MAX_S) begin
                res.slot = bsa_pkg::SLOT_MAX;
                ovf_nxt  = 1'b1;
              end else begin
                res.slot = sum[CW-1:0];
              end
              if (cup_v < bsa_pkg::ITEM_LIM) begin
                cur_we                 = 1'b1;
                cur_wd                 = cup_v + CW'(1);
                cur_vld_nxt[cur_r.idx] = 1'b1;
              end
            end else begin
              res.slot = '1;
            end
          end
          bsa_pkg::K_QUERY: begin
            if (cur_r.idx_ok) begin
              res.bucket_count  = cnt_v;
              res.bucket_offset = off_v;
            end
          end
          default: begin
          end
        endcase
        res.total_count = total_r;
        res.overflow    = ovf_nxt;
        out_nxt         = res;
        out_vld_nxt     = 1'b1;
        state_nxt       = bsa_pkg::B_IDLE;
      end
      bsa_pkg::B_FIN: begin
        // Count for wi_r is in the read register; fetch the next one.
        rd_addr             = wi_r + AW'(1);
        off_we              = 1'b1;
        off_vld_nxt[wi_r]   = 1'b1;
        if ({1'b0, wi_r} < cur_r.nd) begin
          off_wd  = run_r;
          run_sum = {1'b0, run_r} + {1'b0, fin_cnt};
          if (run_sum > bsa_pkg::ITEM_LIM_S) begin
            run_sum = bsa_pkg::ITEM_LIM_S;
            ovf_nxt = 1'b1;
          end
        end else begin
          run_sum = {1'b0, run_r};
        end
        run_nxt = run_sum[CW-1:0];
        wi_nxt  = wi_r + AW'(1);
        if (wi_r == AW'(ND - 1)) begin
          total_nxt       = run_sum[CW-1:0];
          res.total_count = run_sum[CW-1:0];
          res.overflow    = ovf_nxt;
          out_nxt         = res;
          out_vld_nxt     = 1'b1;
          state_nxt       = bsa_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = bsa_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bsa_pkg::B_IDLE;
      out_vld_r <= 1'b0;
      total_r   <= '0;
      ovf_r     <= 1'b0;
      cnt_vld_r <= '0;
      cur_vld_r <= '0;
      off_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      total_r   <= total_nxt;
      ovf_r     <= ovf_nxt;
      cnt_vld_r <= cnt_vld_nxt;
      cur_vld_r <= cur_vld_nxt;
      off_vld_r <= off_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
    wi_r  <= wi_nxt;
    run_r <= run_nxt;
  end

  // Tables: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cur_r.idx] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[off_wa] <= off_wd;
    end
    off_rd_r <= off_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_r.idx] <= cur_wd;
    end
    cur_rd_r <= cur_mem[rd_addr];
  end

  assign out_valid    = out_vld_r;
  assign out_data     = out_r;
  assign stat.busy    = (state_r != bsa_pkg::B_IDLE);
  assign stat.walking = (state_r == bsa_pkg::B_FIN);

endmodule
